/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the byte ring FIFO checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on every clock edge outside reset
`define BRF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Assert that a condition implies another one on the next clock edge
`define BRF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/brf_pkg.sv */
// ----------------------------------------------------------------------------
// brf_pkg
// Types and constants shared by the byte ring FIFO modules.
// ----------------------------------------------------------------------------
package brf_pkg;

  // Store size default and field widths
  localparam int STORE_DEPTH_DEF = 1024;
  localparam int CFG_W           = 11;
  localparam int CNT_W           = 11;
  localparam int DATA_W          = 8;
  localparam int CNT_MAX         = (2 ** CNT_W) - 1;

  localparam logic [CFG_W-1:0] DEPTH_RESET = CFG_W'(1024);

  // Operation codes
  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_READ   = 2'd1,
    KIND_FLUSH  = 2'd2,
    KIND_REWIND = 2'd3
  } kind_t;

  // Input request
  typedef struct packed {
    kind_t              kind;
    logic [DATA_W-1:0]  data_in;
    logic [CNT_W-1:0]   rewind_count;
    logic               burst_last;
  } in_req_t;

  // Result
  typedef struct packed {
    logic [DATA_W-1:0]  data_out;
    logic               accepted;
    logic [CNT_W-1:0]   fill_level;
    logic [CNT_W-1:0]   burst_moved;
    logic [CNT_W-1:0]   rewound;
  } out_rsp_t;

endpackage

/* src/brf_store.sv */
// ----------------------------------------------------------------------------
// brf_store
// Byte store with one write and one registered read port, swept to zero
// after reset.
// ----------------------------------------------------------------------------
module brf_store #(
  parameter int STORE_DEPTH = brf_pkg::STORE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [$clog2(STORE_DEPTH)-1:0]    wr_addr,
  input  logic [brf_pkg::DATA_W-1:0]        wr_data,
  input  logic                              rd_en,
  input  logic [$clog2(STORE_DEPTH)-1:0]    rd_addr,
  output logic [brf_pkg::DATA_W-1:0]        rd_data,
  output logic                              clearing
);
  import brf_pkg::*;

  localparam int PW = $clog2(STORE_DEPTH);

  logic [DATA_W-1:0] mem [STORE_DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic              clr_active_r;
  logic [PW-1:0]     clr_addr_r;

  logic              we;
  logic [PW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;

  // Sweep every entry to zero once after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + PW'(1);
      if (clr_addr_r == PW'(STORE_DEPTH - 1)) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  // Steer the write port to the sweep while it runs
  assign we    = clr_active_r | wr_en;
  assign waddr = clr_active_r ? clr_addr_r : wr_addr;
  assign wdata = clr_active_r ? '0 : wr_data;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port: data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clearing = clr_active_r;

endmodule

/* src/byte_ring_fifo_with_rewind_top.sv */
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_rewind_top
// Circular byte FIFO with flush and rewind, one operation per request.
// ----------------------------------------------------------------------------
// Takes one request per clock cycle (write, read, flush or rewind) while
// in_stall is low. Its result passes from the skid stage into the output
// register and waits there while the output side is stalled.
// Pointer and fill updates are registered at acceptance; the byte store
// has one write port and one read port with a registered read, which is why
// the result is staged. A result register and one skid stage let a new
// request in while a result waits. After reset the store is swept to zero,
// one entry a cycle; in_stall is high during that sweep while
// configuration writes are still taken.
// Writing depth_in_use empties the ring but keeps the stored bytes.
module byte_ring_fifo_with_rewind_top #(
  parameter int STORE_DEPTH = brf_pkg::STORE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  brf_pkg::in_req_t           in_req,
  output logic                       out_valid,
  input  logic                       out_stall,
  output brf_pkg::out_rsp_t          out_rsp,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [brf_pkg::CFG_W-1:0]  cfg_data
);
  import brf_pkg::*;

  localparam int PW   = $clog2(STORE_DEPTH);
  localparam int XW   = ((PW > CNT_W) ? PW : CNT_W) + 1;
  localparam int DMAX = (STORE_DEPTH > CNT_MAX) ? CNT_MAX : STORE_DEPTH;

  // Clamp a configured depth into the usable range
  function automatic logic [CNT_W-1:0] ring_depth(input logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] d;
    d = CNT_W'(v);
    if (d == '0) begin
      d = CNT_W'(1);
    end
    if (d > CNT_W'(DMAX)) begin
      d = CNT_W'(DMAX);
    end
    return d;
  endfunction

  logic [CNT_W-1:0] depth_r;
  logic [PW-1:0]    rp_r, rp_nxt;
  logic [PW-1:0]    wp_r, wp_nxt;
  logic [CNT_W-1:0] held_r, held_nxt;
  logic [CNT_W-1:0] bc_r, bc_nxt;

  logic             s1_valid_r;
  out_rsp_t         s1_rsp_r;
  out_rsp_t         s1_out;
  out_rsp_t         rsp_nxt;
  logic             s1_rd_r;
  logic             out_valid_r;
  out_rsp_t         out_rsp_r;

  logic             clearing;
  logic [DATA_W-1:0] rd_data;
  logic             in_acc, cfg_wr, s1_move;
  logic             wr_en, rd_en;

  logic [XW-1:0]    x_rp, x_wp, x_depth, x_rew;
  logic [XW-1:0]    rp_inc, wp_inc, rp_back;
  logic [CNT_W-1:0] free_cnt, rew;
  logic [CNT_W-1:0] bc_inc;
  logic             full, empty;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;
  assign s1_move   = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall  = clearing | (s1_valid_r & out_valid_r & out_stall);
  assign in_acc    = in_valid & ~in_stall;

  // Pointer arithmetic on widened values
  assign x_rp     = XW'(rp_r);
  assign x_wp     = XW'(wp_r);
  assign x_depth  = XW'(depth_r);
  assign rp_inc   = x_rp + XW'(1);
  assign wp_inc   = x_wp + XW'(1);
  assign full     = (held_r >= depth_r);
  assign empty    = (held_r == '0);
  assign free_cnt = depth_r - held_r;
  assign rew      = (in_req.rewind_count > free_cnt) ? free_cnt : in_req.rewind_count;
  assign x_rew    = XW'(rew);
  assign rp_back  = (x_rp >= x_rew) ? (x_rp - x_rew) : (x_rp + x_depth - x_rew);
  assign bc_inc   = (bc_r < CNT_W'(CNT_MAX)) ? (bc_r + CNT_W'(1)) : bc_r;

  // Decode the request into next state and result
  always_comb begin
    rp_nxt   = rp_r;
    wp_nxt   = wp_r;
    held_nxt = held_r;
    bc_nxt   = bc_r;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    rsp_nxt  = '0;
    unique case (in_req.kind)
      KIND_WRITE: begin
        if (!full) begin
          wr_en            = in_acc;
          wp_nxt           = (wp_inc >= x_depth) ? '0 : PW'(wp_inc);
          held_nxt         = held_r + CNT_W'(1);
          bc_nxt           = bc_inc;
          rsp_nxt.accepted = 1'b1;
        end
        if (in_req.burst_last) begin
          rsp_nxt.burst_moved = bc_nxt;
          bc_nxt              = '0;
        end
      end
      KIND_READ: begin
        if (!empty) begin
          rd_en            = in_acc;
          rp_nxt           = (rp_inc >= x_depth) ? '0 : PW'(rp_inc);
          held_nxt         = held_r - CNT_W'(1);
          bc_nxt           = bc_inc;
          rsp_nxt.accepted = 1'b1;
        end
        if (in_req.burst_last) begin
          rsp_nxt.burst_moved = bc_nxt;
          bc_nxt              = '0;
        end
      end
      KIND_FLUSH: begin
        rp_nxt           = wp_r;
        held_nxt         = '0;
        rsp_nxt.accepted = 1'b1;
      end
      KIND_REWIND: begin
        rp_nxt           = PW'(rp_back);
        held_nxt         = held_r + rew;
        rsp_nxt.rewound  = rew;
        rsp_nxt.accepted = 1'b1;
      end
      default: begin
        rsp_nxt = '0;
      end
    endcase
    rsp_nxt.fill_level = held_nxt;
  end

  // Ring state: configuration empties the ring
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= ring_depth(DEPTH_RESET);
      rp_r    <= '0;
      wp_r    <= '0;
      held_r  <= '0;
      bc_r    <= '0;
    end else if (cfg_wr) begin
      depth_r <= ring_depth(cfg_data);
      rp_r    <= '0;
      wp_r    <= '0;
      held_r  <= '0;
      bc_r    <= '0;
    end else if (in_acc) begin
      rp_r    <= rp_nxt;
      wp_r    <= wp_nxt;
      held_r  <= held_nxt;
      bc_r    <= bc_nxt;
    end
  end

  // Result pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Merge the read byte into the waiting result
  always_comb begin
    s1_out          = s1_rsp_r;
    s1_out.data_out = s1_rd_r ? rd_data : '0;
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_rsp_r <= rsp_nxt;
      s1_rd_r  <= rd_en;
    end
    if (s1_move) begin
      out_rsp_r <= s1_out;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  brf_store #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_addr  (wp_r),
    .wr_data  (in_req.data_in),
    .rd_en    (rd_en),
    .rd_addr  (rp_r),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

endmodule

/* src/brf_checker.sv */
// ----------------------------------------------------------------------------
// brf_checker
// Port-level checks for the byte ring FIFO, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module brf_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input brf_pkg::out_rsp_t out_rsp
);
  import brf_pkg::*;

  logic       in_acc, out_acc;
  logic [1:0] pend_r;

  assign in_acc  = in_valid & ~in_stall;
  assign out_acc = out_valid & ~out_stall;

  // Track requests accepted but not yet answered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  // Hold a stalled result
  `BRF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_rsp), "stalled result changed")
  // Never more in flight than skid stage plus output register
  `BRF_ASSERT(a_pend_max, clk, rst_n, pend_r != 2'd3, "too many requests in flight")
  // No result without an open request
  `BRF_ASSERT(a_no_extra, clk, rst_n, !out_valid || (pend_r != 2'd0), "result without request")
  // An idle pipe answers through the skid stage and the output register
  `BRF_ASSERT(a_latency, clk, rst_n, (in_acc && !out_valid && pend_r == 2'd0) |-> ##2 out_valid, "result latency exceeded")

endmodule

bind byte_ring_fifo_with_rewind_top brf_checker u_brf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_rsp   (out_rsp)
);

/* bench/byte_ring_fifo_with_rewind_top_tb.sv */
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_rewind_top_tb
// Self-checking bench for the circular byte FIFO with flush and rewind.
// ----------------------------------------------------------------------------
// Requests are driven on the falling edge. Each accepted request runs through
// a local model of the ring, which queues the expected result. A monitor pops
// that queue for each result taken on the rising edge and compares every
// field. Directed checks cover empty and full rings, flush, clipped and
// wrapping rewinds, depth clamping and a long burst over a small ring. Random
// burst traffic then runs under several depth settings and sender/receiver
// idle mixes.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_rewind_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import brf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_PHASE = 180;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_req_t             in_req = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_rsp_t            out_rsp;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_data = '0;

  // Local model of the ring
  logic [DATA_W-1:0]   fifo_mem [STORE_DEPTH_DEF];
  logic [9:0]          rd_ptr = '0;
  logic [9:0]          wr_ptr = '0;
  logic [CNT_W-1:0]    fill_count = '0;
  logic [CNT_W-1:0]    burst_count = '0;
  logic [CFG_W-1:0]    depth_reg = DEPTH_RESET;

  out_rsp_t            expected_rsp_q[$];

  int unsigned         send_idle_pct = 0;
  int unsigned         stall_pct = 0;
  int unsigned         mismatches = 0;
  int unsigned         requests_sent = 0;
  int unsigned         results_checked = 0;
  int unsigned         depth_writes = 0;
  int unsigned         cycle_count = 0;

  byte_ring_fifo_with_rewind_top #(
    .STORE_DEPTH(STORE_DEPTH_DEF)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Ring depth as the block uses it: clamp to 1..STORE_DEPTH
  function automatic logic [CFG_W-1:0] ring_depth();
    if (depth_reg == '0) return CFG_W'(1);
    if (depth_reg > CFG_W'(STORE_DEPTH_DEF)) return CFG_W'(STORE_DEPTH_DEF);
    return depth_reg;
  endfunction

  function automatic logic [9:0] next_slot(logic [9:0] ptr, logic [CFG_W-1:0] depth);
    return ({1'b0, ptr} + 11'd1 >= depth) ? '0 : ptr + 10'd1;
  endfunction

  // Apply one request to the model and return the result it produces
  function automatic out_rsp_t predict_result(in_req_t req);
    out_rsp_t         rsp;
    logic [CFG_W-1:0] depth;
    logic [CNT_W-1:0] room;
    logic [CNT_W-1:0] step;
    depth = ring_depth();
    rsp = '0;
    // keep pointers inside the ring
    if ({1'b0, rd_ptr} >= depth) rd_ptr = '0;
    if ({1'b0, wr_ptr} >= depth) wr_ptr = '0;
    if (fill_count > depth) fill_count = depth;
    case (req.kind)
      KIND_WRITE, KIND_READ: begin
        if (req.kind == KIND_WRITE && fill_count < depth) begin
          fifo_mem[wr_ptr] = req.data_in;
          wr_ptr = next_slot(wr_ptr, depth);
          fill_count = fill_count + CNT_W'(1);
          rsp.accepted = 1'b1;
        end else if (req.kind == KIND_READ && fill_count != '0) begin
          rsp.data_out = fifo_mem[rd_ptr];
          rd_ptr = next_slot(rd_ptr, depth);
          fill_count = fill_count - CNT_W'(1);
          rsp.accepted = 1'b1;
        end
        // saturating burst count, reported and cleared on the last request
        if (rsp.accepted && burst_count != CNT_W'(CNT_MAX))
          burst_count = burst_count + CNT_W'(1);
        if (req.burst_last) begin
          rsp.burst_moved = burst_count;
          burst_count = '0;
        end
      end
      KIND_FLUSH: begin
        rd_ptr = wr_ptr;
        fill_count = '0;
        rsp.accepted = 1'b1;
      end
      default: begin
        // rewind, clipped to the free space, wrapping below slot zero
        room = depth - fill_count;
        step = (req.rewind_count > room) ? room : req.rewind_count;
        if ({1'b0, rd_ptr} >= step) rd_ptr = 10'({1'b0, rd_ptr} - step);
        else rd_ptr = 10'({1'b0, rd_ptr} + depth - step);
        fill_count = fill_count + step;
        rsp.accepted = 1'b1;
        rsp.rewound = step;
      end
    endcase
    rsp.fill_level = fill_count;
    return rsp;
  endfunction

  function automatic in_req_t make_req(kind_t k, logic [DATA_W-1:0] data,
                                       logic [CNT_W-1:0] cnt, logic last);
    in_req_t r;
    r.kind = k;
    r.data_in = data;
    r.rewind_count = cnt;
    r.burst_last = last;
    return r;
  endfunction

  // Random payload; unused fields carry random bits too
  function automatic in_req_t rand_req(kind_t k, logic last);
    return make_req(k, DATA_W'($urandom_range(0, 255)), CNT_W'($urandom_range(0, 2047)), last);
  endfunction

  // Drive one request, holding it until accepted, then queue its result
  task automatic send_req(in_req_t req);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (!(in_valid && !in_stall));
    expected_rsp_q.push_back(predict_result(req));
    requests_sent++;
  endtask

  // Hold off the sender until every queued result has come back
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write depth_in_use; the ring empties but the store keeps its bytes
  task automatic write_depth(logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    depth_reg = value;
    rd_ptr = '0;
    wr_ptr = '0;
    fill_count = '0;
    burst_count = '0;
    depth_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Randomly stall the result side
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  function automatic void check_field(string name, logic [CNT_W-1:0] got,
                                      logic [CNT_W-1:0] want);
    if (got !== want) begin
      if (mismatches < 10)
        $display("tb: mismatch on %s in result %0d: expected %0d, got %0d",
                 name, results_checked, want, got);
      mismatches++;
    end
  endfunction

  // Compare each result taken with the oldest expectation
  always @(posedge clk) begin
    out_rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rsp_q.size() == 0) begin
        if (mismatches < 10)
          $display("tb: unexpected result %0d, nothing was pending", results_checked);
        mismatches++;
      end else begin
        want = expected_rsp_q.pop_front();
        check_field("data_out", CNT_W'(out_rsp.data_out), CNT_W'(want.data_out));
        check_field("accepted", CNT_W'(out_rsp.accepted), CNT_W'(want.accepted));
        check_field("fill_level", out_rsp.fill_level, want.fill_level);
        check_field("burst_moved", out_rsp.burst_moved, want.burst_moved);
        check_field("rewound", out_rsp.rewound, want.rewound);
      end
      results_checked++;
    end
  end

  // End the run if it hangs
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // Pushes, pops and an empty read at the reset depth
  task automatic test_basic_ops();
    send_req(make_req(KIND_WRITE, 8'h00, 11'd0, 1'b0));
    send_req(make_req(KIND_WRITE, 8'hFF, 11'h7FF, 1'b1));
    send_req(make_req(KIND_READ, 8'h00, 11'd0, 1'b0));
    send_req(make_req(KIND_READ, 8'hFF, 11'd0, 1'b1));
    send_req(make_req(KIND_READ, 8'h00, 11'd0, 1'b1));
  endtask

  // Flush, rewind back to slot zero, clipped rewind to full, write when full
  task automatic test_flush_and_rewind();
    send_req(make_req(KIND_WRITE, 8'h5A, 11'd0, 1'b0));
    send_req(make_req(KIND_WRITE, 8'hA5, 11'd0, 1'b1));
    send_req(make_req(KIND_FLUSH, 8'h00, 11'd0, 1'b1));
    send_req(make_req(KIND_REWIND, 8'h00, 11'd4, 1'b1));
    send_req(make_req(KIND_READ, 8'h00, 11'd0, 1'b0));
    send_req(make_req(KIND_REWIND, 8'h00, 11'h7FF, 1'b0));
    send_req(make_req(KIND_WRITE, 8'h33, 11'd0, 1'b1));
    send_req(make_req(KIND_REWIND, 8'h00, 11'd0, 1'b1));
    send_req(make_req(KIND_FLUSH, 8'h00, 11'd0, 1'b0));
  endtask

  // Depth zero clamps to one slot, an oversize depth clamps to the store
  task automatic test_depth_extremes();
    wait_for_results();
    write_depth(CFG_W'(0));
    send_req(make_req(KIND_WRITE, 8'hC3, 11'd0, 1'b0));
    send_req(make_req(KIND_WRITE, 8'h3C, 11'd0, 1'b1));
    send_req(make_req(KIND_READ, 8'h00, 11'd0, 1'b0));
    send_req(make_req(KIND_READ, 8'h00, 11'd0, 1'b1));
    send_req(make_req(KIND_REWIND, 8'h00, 11'd1024, 1'b0));
    send_req(make_req(KIND_READ, 8'h00, 11'd0, 1'b1));
    wait_for_results();
    write_depth(CFG_W'(2047));
    send_req(make_req(KIND_WRITE, 8'h81, 11'd0, 1'b1));
    send_req(make_req(KIND_READ, 8'h00, 11'd0, 1'b1));
  endtask

  // One long burst wrapping a two-slot ring many times
  task automatic test_long_burst();
    wait_for_results();
    write_depth(CFG_W'(2));
    for (int i = 0; i < 100; i++) begin
      send_req(rand_req(KIND_WRITE, 1'b0));
      send_req(rand_req(KIND_READ, 1'b0));
    end
    send_req(rand_req(KIND_READ, 1'b1));
  endtask

  // Random bursts with flushes, rewinds and some loose requests
  task automatic test_random_traffic(int unsigned phase, logic [CFG_W-1:0] depth_val);
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    int unsigned span;
    logic        paused;
    kind_t       k;
    in_req_t     req;
    wait_for_results();
    case (phase % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 70; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 70; end
      default: begin send_idle_pct = 28; stall_pct = 28; end
    endcase
    write_depth(depth_val);
    sent = 0;
    paused = 1'b0;
    while (sent < ITEMS_PER_PHASE) begin
      // pause the sender once midway until the ring's results are all back
      if (!paused && sent >= ITEMS_PER_PHASE / 2) begin
        wait_for_results();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      span = ring_depth();
      if (pick < 80) begin
        k = $urandom_range(0, 1) ? KIND_WRITE : KIND_READ;
        len = $urandom_range(1, (span + 2 < 40) ? span + 2 : 40);
        for (int i = 0; i < len; i++) begin
          send_req(rand_req(k, i == len - 1));
          sent++;
        end
      end else if (pick < 88) begin
        send_req(rand_req(KIND_FLUSH, 1'($urandom_range(0, 1))));
        sent++;
      end else if (pick < 96) begin
        req = rand_req(KIND_REWIND, 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 1)) req.rewind_count = CNT_W'($urandom_range(0, span));
        send_req(req);
        sent++;
      end else begin
        send_req(rand_req(kind_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1))));
        sent++;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < STORE_DEPTH_DEF; i++) fifo_mem[i] = '0;
    // hold reset, then release it on a falling edge
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_basic_ops();
    test_flush_and_rewind();
    test_depth_extremes();
    test_long_burst();
    test_random_traffic(0, CFG_W'(1024));
    test_random_traffic(1, CFG_W'(1));
    test_random_traffic(2, CFG_W'(3));
    test_random_traffic(3, CFG_W'($urandom_range(4, 64)));
    test_random_traffic(4, CFG_W'(0));
    test_random_traffic(5, CFG_W'(16));
    test_random_traffic(6, CFG_W'($urandom_range(1025, 2047)));
    test_random_traffic(7, CFG_W'($urandom_range(1, 1024)));

    wait_for_results();
    $display("tb: %0d requests and %0d results checked over %0d depth settings",
             requests_sent, results_checked, depth_writes);
    $display("tb: idle mixes: none, sender 70%%, receiver 70%%, both 28%%; %0d mismatches",
             mismatches);
    if (mismatches == 0 && expected_rsp_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* byte_ring_fifo_with_rewind_top.f */
+incdir+src
src/brf_pkg.sv
src/brf_store.sv
src/byte_ring_fifo_with_rewind_top.sv
src/brf_checker.sv
bench/byte_ring_fifo_with_rewind_top_tb.sv
